[rtl/vpr_pkg.sv]
// Package for the visibility phase rotator: widths, pipeline layout,
// reciprocal and CORDIC constants, shared types.
// No dependencies.
package vpr_pkg;

  localparam int PHASE_BITS = 32;

  // Pipeline layout
  localparam int PHASE_STAGES    = 5;
  localparam int CORDIC_STEPS    = 30;
  localparam int STEPS_PER_STAGE = 3;
  localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int MUL_STAGES      = 2;
  localparam int CORDIC_BASE     = PHASE_STAGES;
  localparam int MUL_BASE        = PHASE_STAGES + CORDIC_STAGES;
  localparam int NSTAGE          = PHASE_STAGES + CORDIC_STAGES + MUL_STAGES;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;

  // round(2^88 / speed of light in mm/s)
  localparam logic [127:0] LIGHT_MM    = 128'd299792458000;
  localparam logic [127:0] RECIP_WIDE  = ((128'd1 << 88) + (LIGHT_MM >> 1)) / LIGHT_MM;
  localparam logic [49:0]  RECIP_LIGHT = RECIP_WIDE[49:0];

  // gain-compensated 1.0 in Q.30
  localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_OFFSET  = 2'd0,
    CFG_Y_OFFSET  = 2'd1,
    CFG_WIDE_MODE = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  // visibility carried alongside the phase path
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               shift_en;
  } vis_t;

endpackage

[rtl/vpr_ctrl.sv]
// Valid/enable chain for the rotator pipeline; bubbles collapse under stall.
// Depends on vpr_pkg.
module vpr_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       out_ready_i,
  output logic [vpr_pkg::NSTAGE-1:0] en_o,
  output logic [vpr_pkg::NSTAGE-1:0] vld_o,
  output logic                       in_ready_o,
  output logic                       out_valid_o
);
  import vpr_pkg::*;

  logic [NSTAGE-1:0] vld_q, vld_d, en;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[NSTAGE-1] = !vld_q[NSTAGE-1] || out_ready_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign en_o        = en;
  assign vld_o       = vld_q;
  assign in_ready_o  = en[0];
  assign out_valid_o = vld_q[NSTAGE-1];

endmodule

[rtl/vpr_phase.sv]
// Phase computation: offset*uv*f/c or f*rate, wrapped to a 32-bit turn angle.
// Multiplies are split into partial products on 32-bit word boundaries. Depends on vpr_pkg.
module vpr_phase (
  input  logic                             clk_i,
  input  logic [vpr_pkg::PHASE_STAGES-1:0] en_i,
  input  vpr_pkg::vis_t                    vis_i,
  input  logic signed [39:0]               u_coord_i,
  input  logic signed [39:0]               v_coord_i,
  input  logic [39:0]                      freq_hz_i,
  input  logic [63:0]                      row_rate_i,
  input  logic signed [47:0]               x_offset_i,
  input  logic signed [47:0]               y_offset_i,
  input  logic                             wide_mode_i,
  output logic [31:0]                      angle_o,
  output vpr_pkg::vis_t                    vis_o
);
  import vpr_pkg::*;

  vis_t vis_q [PHASE_STAGES];

  // stage 0: partial products
  logic        [63:0] xll_q, yll_q;
  logic signed [40:0] xlh_q, ylh_q;
  logic signed [48:0] xhl_q, yhl_q;
  logic signed [23:0] xhh_q, yhh_q;
  logic        [63:0] gll_q;
  logic        [49:0] glh_q;
  logic        [39:0] ghl_q;
  logic        [25:0] ghh_q;
  logic        [63:0] w00_q, w01_q;
  logic        [39:0] w10_q;

  // stage 1: sums
  logic signed [88:0] s_d, s_q;
  logic        [89:0] g_d, g_q;
  logic        [63:0] w_d, w_q;

  // stage 2: cross products of S and f*R
  logic [127:0] s_ext;
  logic [31:0]  s0, s1, s2, s3, g0, g1, g2;
  logic [63:0]  p00_q, p01_q, p02_q, p10_q, p11_q, p12_q, p20_q, p21_q, p30_q;
  logic [63:0]  wneg;
  logic [PHASE_BITS-1:0] wph2_q, wph3_q;

  // stage 3/4
  logic [127:0] z_d, z_q, zneg;
  logic [PHASE_BITS-1:0]    ph;
  logic [PHASE_BITS+31:0]   ph_ext;
  logic [31:0]              angle_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      xll_q <= x_offset_i[31:0] * u_coord_i[31:0];
      yll_q <= y_offset_i[31:0] * v_coord_i[31:0];
      xlh_q <= $signed({1'b0, x_offset_i[31:0]}) * $signed(u_coord_i[39:32]);
      ylh_q <= $signed({1'b0, y_offset_i[31:0]}) * $signed(v_coord_i[39:32]);
      xhl_q <= $signed(x_offset_i[47:32]) * $signed({1'b0, u_coord_i[31:0]});
      yhl_q <= $signed(y_offset_i[47:32]) * $signed({1'b0, v_coord_i[31:0]});
      xhh_q <= $signed(x_offset_i[47:32]) * $signed(u_coord_i[39:32]);
      yhh_q <= $signed(y_offset_i[47:32]) * $signed(v_coord_i[39:32]);
      gll_q <= freq_hz_i[31:0] * RECIP_LIGHT[31:0];
      glh_q <= freq_hz_i[31:0] * RECIP_LIGHT[49:32];
      ghl_q <= freq_hz_i[39:32] * RECIP_LIGHT[31:0];
      ghh_q <= freq_hz_i[39:32] * RECIP_LIGHT[49:32];
      w00_q <= freq_hz_i[31:0] * row_rate_i[31:0];
      w01_q <= freq_hz_i[31:0] * row_rate_i[63:32];
      w10_q <= freq_hz_i[39:32] * row_rate_i[31:0];
    end
  end

  always_comb begin
    s_d = $signed({25'd0, xll_q}) + $signed({25'd0, yll_q})
        + ((89'(xlh_q) + 89'(xhl_q) + 89'(ylh_q) + 89'(yhl_q)) <<< 32)
        + ((89'(xhh_q) + 89'(yhh_q)) <<< 64);
    g_d = 90'(gll_q) + (90'(glh_q) << 32) + (90'(ghl_q) << 32) + (90'(ghh_q) << 64);
    // wide mode keeps only the low 64 bits of f*rate
    w_d = w00_q + ((w01_q + 64'(w10_q)) << 32);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s_q <= s_d;
      g_q <= g_d;
      w_q <= w_d;
    end
  end

  always_comb begin
    s_ext = {{39{s_q[88]}}, s_q};
    s0    = s_ext[31:0];
    s1    = s_ext[63:32];
    s2    = s_ext[95:64];
    s3    = s_ext[127:96];
    g0    = g_q[31:0];
    g1    = g_q[63:32];
    g2    = {6'd0, g_q[89:64]};
    wneg  = 64'd0 - w_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      p00_q  <= s0 * g0;
      p01_q  <= s0 * g1;
      p02_q  <= s0 * g2;
      p10_q  <= s1 * g0;
      p11_q  <= s1 * g1;
      p12_q  <= s1 * g2;
      p20_q  <= s2 * g0;
      p21_q  <= s2 * g1;
      p30_q  <= s3 * g0;
      wph2_q <= wneg[63 -: PHASE_BITS];
    end
  end

  // product modulo 2^128; top column only contributes its low word
  assign z_d = 128'(p00_q)
             + ((128'(p01_q) + 128'(p10_q)) << 32)
             + ((128'(p02_q) + 128'(p11_q) + 128'(p20_q)) << 64)
             + ((128'(p12_q) + 128'(p21_q) + 128'(p30_q)) << 96);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      z_q    <= z_d;
      wph3_q <= wph2_q;
    end
  end

  always_comb begin
    zneg   = 128'd0 - z_q;
    ph     = wide_mode_i ? wph3_q : zneg[127 -: PHASE_BITS];
    ph_ext = {ph, 32'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      angle_q <= ph_ext[PHASE_BITS+31 -: 32];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      vis_q[0] <= vis_i;
    end
    for (int k = 1; k < PHASE_STAGES; k++) begin
      if (en_i[k]) begin
        vis_q[k] <= vis_q[k-1];
      end
    end
  end

  assign angle_o = angle_q;
  assign vis_o   = vis_q[PHASE_STAGES-1];

endmodule

[rtl/vpr_cordic.sv]
// Pipelined rotation-mode CORDIC, a few micro-rotations per stage.
// Turns a 32-bit turn angle into quadrant plus first-quadrant (x, y). Depends on vpr_pkg.
module vpr_cordic (
  input  logic                              clk_i,
  input  logic [vpr_pkg::CORDIC_STAGES-1:0] en_i,
  input  logic [31:0]                       angle_i,
  input  vpr_pkg::vis_t                     vis_i,
  output logic signed [33:0]                x_o,
  output logic signed [33:0]                y_o,
  output vpr_pkg::quad_e                    quad_o,
  output vpr_pkg::vis_t                     vis_o
);
  import vpr_pkg::*;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } cord_t;

  function automatic cord_t cord_steps(cord_t a, int base);
    cord_t              r;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    int                 n;
    r = a;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      n  = base + i;
      dx = r.y >>> n;
      dy = r.x >>> n;
      if (!r.z[32]) begin
        r.x = r.x - dx;
        r.y = r.y + dy;
        r.z = r.z - $signed(33'(ATAN_TURNS[n]));
      end else begin
        r.x = r.x + dx;
        r.y = r.y - dy;
        r.z = r.z + $signed(33'(ATAN_TURNS[n]));
      end
    end
    return r;
  endfunction

  cord_t cord_q [CORDIC_STAGES];
  cord_t cord_d [CORDIC_STAGES];
  quad_e quad_q [CORDIC_STAGES];
  vis_t  vis_q  [CORDIC_STAGES];
  cord_t init;

  always_comb begin
    init.x = CORDIC_X0;
    init.y = '0;
    init.z = $signed({3'b000, angle_i[29:0]});
    cord_d[0] = cord_steps(init, 0);
    for (int g = 1; g < CORDIC_STAGES; g++) begin
      cord_d[g] = cord_steps(cord_q[g-1], g * STEPS_PER_STAGE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cord_q[0] <= cord_d[0];
      quad_q[0] <= quad_e'(angle_i[31:30]);
      vis_q[0]  <= vis_i;
    end
    for (int g = 1; g < CORDIC_STAGES; g++) begin
      if (en_i[g]) begin
        cord_q[g] <= cord_d[g];
        quad_q[g] <= quad_q[g-1];
        vis_q[g]  <= vis_q[g-1];
      end
    end
  end

  assign x_o    = cord_q[CORDIC_STAGES-1].x;
  assign y_o    = cord_q[CORDIC_STAGES-1].y;
  assign quad_o = quad_q[CORDIC_STAGES-1];
  assign vis_o  = vis_q[CORDIC_STAGES-1];

endmodule

[rtl/vpr_cmul.sv]
// Quadrant fold, complex multiply, rounding and 32-bit saturation.
// Last stage is the output register. Depends on vpr_pkg.
module vpr_cmul (
  input  logic                           clk_i,
  input  logic [vpr_pkg::MUL_STAGES-1:0] en_i,
  input  logic signed [33:0]             x_i,
  input  logic signed [33:0]             y_i,
  input  vpr_pkg::quad_e                 quad_i,
  input  vpr_pkg::vis_t                  vis_i,
  output logic signed [31:0]             out_re_o,
  output logic signed [31:0]             out_im_o,
  output logic                           saturated_o
);
  import vpr_pkg::*;

  localparam logic signed [66:0] ROUND_HALF = 67'sd536870912;
  localparam logic signed [66:0] SAT_MAX    = 67'sd2147483647;
  localparam logic signed [66:0] SAT_MIN    = -67'sd2147483648;

  logic signed [33:0] cos_v, sin_v;
  logic signed [65:0] rc_q, is_q, rs_q, ic_q;
  vis_t               vis_q;

  logic signed [66:0] sum_re, sum_im, sh_re, sh_im;
  logic signed [31:0] re_d, im_d, out_re_q, out_im_q;
  logic               sat_d, sat_q;

  always_comb begin
    unique case (quad_i)
      QUAD_I:   begin cos_v = x_i;  sin_v = y_i;  end
      QUAD_II:  begin cos_v = -y_i; sin_v = x_i;  end
      QUAD_III: begin cos_v = -x_i; sin_v = -y_i; end
      QUAD_IV:  begin cos_v = y_i;  sin_v = -x_i; end
      default:  begin cos_v = x_i;  sin_v = y_i;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rc_q  <= vis_i.re * cos_v;
      is_q  <= vis_i.im * sin_v;
      rs_q  <= vis_i.re * sin_v;
      ic_q  <= vis_i.im * cos_v;
      vis_q <= vis_i;
    end
  end

  always_comb begin
    sum_re = 67'(rc_q) - 67'(is_q) + ROUND_HALF;
    sum_im = 67'(rs_q) + 67'(ic_q) + ROUND_HALF;
    sh_re  = sum_re >>> 30;
    sh_im  = sum_im >>> 30;
    sat_d  = 1'b0;
    if (sh_re > SAT_MAX) begin
      re_d  = SAT_MAX[31:0];
      sat_d = 1'b1;
    end else if (sh_re < SAT_MIN) begin
      re_d  = SAT_MIN[31:0];
      sat_d = 1'b1;
    end else begin
      re_d = sh_re[31:0];
    end
    if (sh_im > SAT_MAX) begin
      im_d  = SAT_MAX[31:0];
      sat_d = 1'b1;
    end else if (sh_im < SAT_MIN) begin
      im_d  = SAT_MIN[31:0];
      sat_d = 1'b1;
    end else begin
      im_d = sh_im[31:0];
    end
    // bypass: visibility unchanged, never flagged
    if (!vis_q.shift_en) begin
      re_d  = vis_q.re;
      im_d  = vis_q.im;
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      out_re_q <= re_d;
      out_im_q <= im_d;
      sat_q    <= sat_d;
    end
  end

  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign saturated_o = sat_q;

endmodule

[rtl/visibility_phase_rotator.sv]
// Visibility phase rotator top level: config registers, pipeline control,
// phase, CORDIC and multiply stages. Depends on vpr_pkg and the vpr_* modules.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one visibility per
//   transaction with its u, v, frequency, per-row rate and shift enable.
//   Output channel (out_valid_o/out_ready_i) returns the rotated, saturated
//   visibility and a clip flag, one result per input, in order.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 x offset,
//   1 y offset, 2 wide mode); other indexes are dropped. Write only while idle.
//   Pipeline: 17 register stages in all (5 phase stages, 10 CORDIC stages
//   of 3 micro-rotations each, 2 multiply/saturate stages); out_valid_o rises
//   once a transaction has passed through all of them.
//   Throughput: one transaction per cycle while the output is not stalled,
//   set by the fully pipelined datapath.
//   Stall: each stage holds only while it is full and the one after it is held,
//   so empty slots fill up and inputs are taken until all 17 stages are full.
//   Reset: clears all valid bits and the config registers to zero.
module visibility_phase_rotator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [31:0]              vis_re_i,
  input  logic signed [31:0]              vis_im_i,
  input  logic signed [39:0]              u_coord_i,
  input  logic signed [39:0]              v_coord_i,
  input  logic [39:0]                     freq_hz_i,
  input  logic signed [63:0]              row_rate_i,
  input  logic                            shift_enable_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              out_re_o,
  output logic signed [31:0]              out_im_o,
  output logic                            saturated_o,
  input  logic                            cfg_we_i,
  input  logic [vpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vpr_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import vpr_pkg::*;

  logic signed [47:0] x_offset_q, x_offset_d, y_offset_q, y_offset_d;
  logic               wide_mode_q, wide_mode_d;

  logic [NSTAGE-1:0]  en, vld;
  vis_t               vis_in, vis_ph, vis_cd;
  logic [31:0]        angle;
  logic signed [33:0] cx, cy;
  quad_e              quad;

  always_comb begin
    x_offset_d  = x_offset_q;
    y_offset_d  = y_offset_q;
    wide_mode_d = wide_mode_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_X_OFFSET:  x_offset_d  = cfg_data_i;
        CFG_Y_OFFSET:  y_offset_d  = cfg_data_i;
        CFG_WIDE_MODE: wide_mode_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_offset_q  <= '0;
      y_offset_q  <= '0;
      wide_mode_q <= 1'b0;
    end else begin
      x_offset_q  <= x_offset_d;
      y_offset_q  <= y_offset_d;
      wide_mode_q <= wide_mode_d;
    end
  end

  assign vis_in.re       = vis_re_i;
  assign vis_in.im       = vis_im_i;
  assign vis_in.shift_en = shift_enable_i;

  vpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .en_o        (en),
    .vld_o       (vld),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  vpr_phase u_phase (
    .clk_i       (clk_i),
    .en_i        (en[PHASE_STAGES-1:0]),
    .vis_i       (vis_in),
    .u_coord_i   (u_coord_i),
    .v_coord_i   (v_coord_i),
    .freq_hz_i   (freq_hz_i),
    .row_rate_i  (row_rate_i),
    .x_offset_i  (x_offset_q),
    .y_offset_i  (y_offset_q),
    .wide_mode_i (wide_mode_q),
    .angle_o     (angle),
    .vis_o       (vis_ph)
  );

  vpr_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en[CORDIC_BASE +: CORDIC_STAGES]),
    .angle_i (angle),
    .vis_i   (vis_ph),
    .x_o     (cx),
    .y_o     (cy),
    .quad_o  (quad),
    .vis_o   (vis_cd)
  );

  vpr_cmul u_cmul (
    .clk_i       (clk_i),
    .en_i        (en[MUL_BASE +: MUL_STAGES]),
    .x_i         (cx),
    .y_i         (cy),
    .quad_i      (quad),
    .vis_i       (vis_cd),
    .out_re_o    (out_re_o),
    .out_im_o    (out_im_o),
    .saturated_o (saturated_o)
  );

  // an empty output slot frees the whole chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output stage");

  // a full pipeline under stall must refuse input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld) && !out_ready_i) |-> !in_ready_o)
    else $error("input taken into a full stalled pipeline");

  // an accepted transaction lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld[0])
    else $error("accepted transaction lost at pipeline entry");

endmodule
